/* hdl/wti_pkg.sv */
// Shared types and constants for the waypoint track interpolator.
package wti_pkg;

  localparam int ELAPSED_W = 32;
  localparam int DUR_W     = 20;
  localparam int QUO_W     = 32;
  localparam int VAL_W     = 33;
  localparam int DIF_W     = 34;
  localparam int NUM_W     = 56;
  localparam int LANES     = 5;
  localparam int BATT_W    = 14;
  localparam int PITCH_W   = 12;
  localparam int ROLL_W    = 13;

  localparam int LN_LAT = 0;
  localparam int LN_LON = 1;
  localparam int LN_ALT = 2;
  localparam int LN_SPD = 3;
  localparam int LN_HDG = 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [BATT_W-1:0] BATT_FULL = 14'd10000;

  // Reciprocal constants: x/10 = (x*RECIP_DIV10)>>35, x/5 = (x*RECIP_DIV5)>>34,
  // x/3 = (x*RECIP_DIV3)>>17, exact over the operand ranges used here.
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_DIV5  = 32'hCCCC_CCCD;
  localparam logic [15:0] RECIP_DIV3  = 16'hAAAB;

  localparam logic [10:0] PITCH_LIM = 11'd2000;
  localparam logic [11:0] ROLL_LIM  = 12'd3000;

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [24:0] alt;
    logic [16:0]        spd;
    logic [15:0]        hdg;
  } wpt_t;

endpackage

/* hdl/wti_mod_pipe.sv */
// Pipelined restoring modulo: one remainder bit of the elapsed time per stage.
module wti_mod_pipe #(
  parameter int PW = 23,
  parameter int SW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [wti_pkg::ELAPSED_W-1:0] in_e,
  input  logic [PW-1:0]                 in_mod,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_vld,
  output logic [PW-1:0]                 out_rem,
  output logic [SW-1:0]                 out_side,
  output logic                          busy
);
  import wti_pkg::*;

  localparam int NS = ELAPSED_W;

  logic                 vld_r  [0:NS];
  logic [PW-1:0]        rem_r  [0:NS];
  logic [ELAPSED_W-1:0] sh_r   [0:NS];
  logic [PW-1:0]        mod_r  [0:NS];
  logic [SW-1:0]        side_r [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      sh_r[0]   <= in_e;
      mod_r[0]  <= in_mod;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [PW:0]          sft;
    logic [PW-1:0]        rem_c;
    logic [ELAPSED_W-1:0] sh_c;

    always_comb begin
      sft = {rem_r[k-1], sh_r[k-1][ELAPSED_W-1]};
      if (sft >= {1'b0, mod_r[k-1]}) begin
        rem_c = PW'(sft - {1'b0, mod_r[k-1]});
      end else begin
        rem_c = sft[PW-1:0];
      end
      sh_c = {sh_r[k-1][ELAPSED_W-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_c;
        sh_r[k]   <= sh_c;
        mod_r[k]  <= mod_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i <= NS; i++) begin
      busy = busy | vld_r[i];
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_rem  = rem_r[NS];
  assign out_side = side_r[NS];

endmodule

/* hdl/wti_div_pipe.sv */
// Pipelined signed divider lanes sharing one divisor, one quotient bit per stage.
module wti_div_pipe #(
  parameter int SW = 8
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              in_vld,
  input  logic [wti_pkg::LANES-1:0][wti_pkg::NUM_W-1:0]     in_num,
  input  logic [wti_pkg::DUR_W-1:0]                         in_dur,
  input  logic [SW-1:0]                                     in_side,
  output logic                                              out_vld,
  output logic [wti_pkg::LANES-1:0][wti_pkg::VAL_W-1:0]     out_quo,
  output logic [SW-1:0]                                     out_side,
  output logic                                              busy
);
  import wti_pkg::*;

  localparam int NS = QUO_W;

  logic                             vld_r  [0:NS];
  logic [LANES-1:0][DUR_W-1:0]      rem_r  [0:NS];
  logic [LANES-1:0][QUO_W-1:0]      sh_r   [0:NS];
  logic [LANES-1:0]                 neg_r  [0:NS];
  logic [DUR_W-1:0]                 dur_r  [0:NS];
  logic [SW-1:0]                    side_r [0:NS];

  logic [LANES-1:0][NUM_W-1:0] mag_c;
  logic [LANES-1:0]            neg_c;

  // The quotient magnitude always fits 32 bits, so the top slice starts below the divisor.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_c[l] = in_num[l][NUM_W-1];
      mag_c[l] = neg_c[l] ? (~in_num[l] + NUM_W'(1)) : in_num[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= mag_c[l][QUO_W +: DUR_W];
        sh_r[0][l]  <= mag_c[l][QUO_W-1:0];
      end
      neg_r[0]  <= neg_c;
      dur_r[0]  <= in_dur;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    logic [LANES-1:0][DUR_W:0]   sft;
    logic [LANES-1:0][DUR_W-1:0] rem_c;
    logic [LANES-1:0][QUO_W-1:0] sh_c;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        sft[l] = {rem_r[k-1][l], sh_r[k-1][l][QUO_W-1]};
        if (sft[l] >= {1'b0, dur_r[k-1]}) begin
          rem_c[l] = DUR_W'(sft[l] - {1'b0, dur_r[k-1]});
          sh_c[l]  = {sh_r[k-1][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_c[l] = sft[l][DUR_W-1:0];
          sh_c[l]  = {sh_r[k-1][l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_c;
        sh_r[k]   <= sh_c;
        neg_r[k]  <= neg_r[k-1];
        dur_r[k]  <= dur_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = neg_r[NS][l] ? (~{1'b0, sh_r[NS][l]} + VAL_W'(1)) : {1'b0, sh_r[NS][l]};
    end
    busy = 1'b0;
    for (int i = 0; i <= NS; i++) begin
      busy = busy | vld_r[i];
    end
  end

  assign out_vld  = vld_r[NS];
  assign out_side = side_r[NS];

endmodule

/* hdl/waypoint_track_interpolator.sv */
// Waypoint track interpolator top level: waypoint table, segment search, interpolation.
// A query can enter every cycle while the output is not stalled; its path runs through
// the 32-stage modulo pipeline and the 32-stage divider lanes that follow it.
// A load is taken once no query is in flight, and yields no transaction.
// Synchronous active-low reset clears the pipeline valids, the duration sums and sets
// the waypoint count to eight; the waypoint table itself holds no reset value.
module waypoint_track_interpolator #(
  parameter int MAX_WAYPOINTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [2:0]         in_slot,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [24:0] in_altitude,
  input  logic [16:0]        in_speed,
  input  logic [15:0]        in_heading,
  input  logic [19:0]        in_duration,
  input  logic [31:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [30:0] out_pos_latitude,
  output logic signed [31:0] out_pos_longitude,
  output logic signed [24:0] out_pos_altitude,
  output logic [16:0]        out_cur_speed,
  output logic [15:0]        out_yaw,
  output logic signed [11:0] out_pitch,
  output logic signed [12:0] out_roll,
  output logic [13:0]        out_battery
);
  import wti_pkg::*;

  localparam int IW  = $clog2(MAX_WAYPOINTS);
  localparam int NW  = IW + 1;
  localparam int PW  = DUR_W + IW;
  localparam int MSW = 1 + NW + BATT_W;
  localparam int DSW = PITCH_W + ROLL_W + BATT_W;

  logic en, busy, m_busy, d_busy;
  logic in_acc, qry_acc, ld_acc;
  logic [IW-1:0] slot_idx;

  logic [3:0]       cnt_r;
  logic [DUR_W-1:0] dur_r [MAX_WAYPOINTS];
  logic [PW-1:0]    pre_r [MAX_WAYPOINTS];
  wpt_t             tbl_mem [MAX_WAYPOINTS];

  logic [NW-1:0] n_c;
  logic [PW-1:0] loop_c;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en || ((in_kind == KIND_LOAD) && busy);
  assign in_acc   = in_valid && !in_stall;
  assign qry_acc  = in_acc && (in_kind == KIND_QUERY);
  assign ld_acc   = in_acc && (in_kind == KIND_LOAD) && (32'(in_slot) < MAX_WAYPOINTS);
  assign slot_idx = IW'(in_slot);

  always_comb begin
    if (cnt_r == '0) begin
      n_c = NW'(1);
    end else if (32'(cnt_r) > MAX_WAYPOINTS) begin
      n_c = NW'(MAX_WAYPOINTS);
    end else begin
      n_c = NW'(cnt_r);
    end
    loop_c = pre_r[IW'(n_c - NW'(1))];
  end

  // Configuration and table maintenance. pre_r holds running sums of the durations.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd8;
      for (int i = 0; i < MAX_WAYPOINTS; i++) begin
        dur_r[i] <= '0;
        pre_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      if (ld_acc) begin
        dur_r[slot_idx] <= in_duration;
        for (int i = 0; i < MAX_WAYPOINTS; i++) begin
          if (i >= int'(slot_idx)) begin
            pre_r[i] <= pre_r[i] - PW'(dur_r[slot_idx]) + PW'(in_duration);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      tbl_mem[slot_idx] <= '{lat: in_latitude, lon: in_longitude, alt: in_altitude,
                             spd: in_speed, hdg: in_heading};
    end
  end

  // Entry and battery stages.
  logic          s0_vld_r, s1_vld_r;
  logic [31:0]   s0_e_r, s1_e_r;
  logic [NW-1:0] s0_n_r, s1_n_r;
  logic [PW-1:0] s0_loop_r, s1_loop_r;
  logic [28:0]   s1_drain_r;
  logic [63:0]   prod10_c;
  logic [BATT_W-1:0] bat_c;

  assign prod10_c = 64'(s0_e_r) * 64'(RECIP_DIV10);
  assign bat_c    = (s1_drain_r >= 29'(BATT_FULL)) ? '0 : BATT_FULL - s1_drain_r[BATT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= qry_acc;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_e_r     <= in_elapsed_ms;
      s0_n_r     <= n_c;
      s0_loop_r  <= loop_c;
      s1_e_r     <= s0_e_r;
      s1_n_r     <= s0_n_r;
      s1_loop_r  <= s0_loop_r;
      s1_drain_r <= prod10_c[63:35];
    end
  end

  logic           m_vld;
  logic [PW-1:0]  m_rem;
  logic [MSW-1:0] m_side;
  logic           m_zero;
  logic [NW-1:0]  m_n;
  logic [BATT_W-1:0] m_bat;
  logic [PW-1:0]  t_c;

  wti_mod_pipe #(.PW(PW), .SW(MSW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s1_vld_r),
    .in_e     (s1_e_r),
    .in_mod   (s1_loop_r),
    .in_side  ({(s1_loop_r == '0), s1_n_r, bat_c}),
    .out_vld  (m_vld),
    .out_rem  (m_rem),
    .out_side (m_side),
    .busy     (m_busy)
  );

  assign {m_zero, m_n, m_bat} = m_side;
  // With an empty loop the wrapped time is zero.
  assign t_c = m_zero ? '0 : m_rem;

  // Segment search: compare against every running sum in use, then pick the first hit.
  logic                     s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic [MAX_WAYPOINTS-1:0] s2_lt_r, lt_c;
  logic [PW-1:0]            s2_t_r, s3_t_r;
  logic [NW-1:0]            s2_n_r, s3_n_r;
  logic [BATT_W-1:0]        s2_bat_r, s3_bat_r, s4_bat_r, s5_bat_r, s6_bat_r;
  logic [IW-1:0]            seg_c, nxt_c, s3_seg_r, s3_nxt_r;
  logic                     fnd_c, s3_fnd_r;

  always_comb begin
    for (int i = 0; i < MAX_WAYPOINTS; i++) begin
      lt_c[i] = (i < int'(m_n)) && (t_c < pre_r[i]);
    end
  end

  always_comb begin
    seg_c = IW'(s2_n_r - NW'(1));
    fnd_c = 1'b0;
    for (int i = MAX_WAYPOINTS - 1; i >= 0; i--) begin
      if (s2_lt_r[i]) begin
        seg_c = IW'(i);
        fnd_c = 1'b1;
      end
    end
    if (({1'b0, seg_c} + NW'(1)) == s2_n_r) begin
      nxt_c = '0;
    end else begin
      nxt_c = seg_c + IW'(1);
    end
  end

  // Read stage: table entries at both segment ends, offset and duration.
  wpt_t             s4_a_r, s4_b_r;
  logic [DUR_W-1:0] s4_off_r, s4_dur_r;
  logic [PW-1:0]    acc_c, span_c;
  logic [DUR_W-1:0] off_c, dur_c;

  always_comb begin
    acc_c  = (s3_seg_r == '0) ? '0 : pre_r[s3_seg_r - IW'(1)];
    span_c = pre_r[s3_seg_r] - acc_c;
    off_c  = s3_fnd_r ? DUR_W'(s3_t_r - acc_c) : '0;
    // A zero-length segment yields its start value; divide by one with zero offset.
    dur_c  = (span_c[DUR_W-1:0] == '0) ? DUR_W'(1) : span_c[DUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a_r <= tbl_mem[s3_seg_r];
      s4_b_r <= tbl_mem[s3_nxt_r];
    end
  end

  // Difference, multiply and sum stages.
  logic signed [VAL_W-1:0] a_c [LANES];
  logic signed [VAL_W-1:0] b_c [LANES];
  logic signed [VAL_W-1:0] s5_a_r [LANES];
  logic signed [DIF_W-1:0] s5_d_r [LANES];
  logic [DUR_W-1:0]        s5_off_r, s5_dur_r, s6_dur_r, s7_dur_r;
  logic signed [NUM_W-1:0] s6_p1_r [LANES];
  logic signed [NUM_W-1:0] s6_p2_r [LANES];
  logic [LANES-1:0][NUM_W-1:0] s7_num_r;
  logic [25:0]             abs5_c;
  logic [15:0]             abs3_c;
  logic [57:0]             prod5_c;
  logic [31:0]             prod3_c;
  logic [23:0]             s6_q5_r;
  logic [14:0]             s6_q3_r;
  logic                    s6_n5_r, s6_n3_r;
  logic [10:0]             q5_c;
  logic [11:0]             q3_c;
  logic [DSW-1:0]          s7_side_r;

  always_comb begin
    a_c[LN_LAT] = VAL_W'(s4_a_r.lat);
    a_c[LN_LON] = VAL_W'(s4_a_r.lon);
    a_c[LN_ALT] = VAL_W'(s4_a_r.alt);
    a_c[LN_SPD] = VAL_W'(s4_a_r.spd);
    a_c[LN_HDG] = VAL_W'(s4_a_r.hdg);
    b_c[LN_LAT] = VAL_W'(s4_b_r.lat);
    b_c[LN_LON] = VAL_W'(s4_b_r.lon);
    b_c[LN_ALT] = VAL_W'(s4_b_r.alt);
    b_c[LN_SPD] = VAL_W'(s4_b_r.spd);
    b_c[LN_HDG] = VAL_W'(s4_b_r.hdg);
  end

  always_comb begin
    abs5_c  = s5_d_r[LN_ALT][DIF_W-1] ? 26'(-s5_d_r[LN_ALT]) : 26'(s5_d_r[LN_ALT]);
    abs3_c  = s5_d_r[LN_HDG][DIF_W-1] ? 16'(-s5_d_r[LN_HDG]) : 16'(s5_d_r[LN_HDG]);
    prod5_c = 58'(abs5_c) * 58'(RECIP_DIV5);
    prod3_c = 32'(abs3_c) * 32'(RECIP_DIV3);
    q5_c    = (s6_q5_r > 24'(PITCH_LIM)) ? PITCH_LIM : s6_q5_r[10:0];
    q3_c    = (s6_q3_r > 15'(ROLL_LIM)) ? ROLL_LIM : s6_q3_r[11:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= m_vld;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lt_r  <= lt_c;
      s2_t_r   <= t_c;
      s2_n_r   <= m_n;
      s2_bat_r <= m_bat;
      s3_seg_r <= seg_c;
      s3_nxt_r <= nxt_c;
      s3_fnd_r <= fnd_c;
      s3_t_r   <= s2_t_r;
      s3_n_r   <= s2_n_r;
      s3_bat_r <= s2_bat_r;
      s4_off_r <= off_c;
      s4_dur_r <= dur_c;
      s4_bat_r <= s3_bat_r;
      for (int l = 0; l < LANES; l++) begin
        s5_a_r[l]   <= a_c[l];
        s5_d_r[l]   <= DIF_W'(b_c[l]) - DIF_W'(a_c[l]);
        s6_p1_r[l]  <= NUM_W'(s5_a_r[l]) * NUM_W'($signed({1'b0, s5_dur_r}));
        s6_p2_r[l]  <= NUM_W'(s5_d_r[l]) * NUM_W'($signed({1'b0, s5_off_r}));
        s7_num_r[l] <= s6_p1_r[l] + s6_p2_r[l];
      end
      s5_off_r <= s4_off_r;
      s5_dur_r <= s4_dur_r;
      s5_bat_r <= s4_bat_r;
      s6_dur_r <= s5_dur_r;
      s6_bat_r <= s5_bat_r;
      s6_q5_r  <= prod5_c[57:34];
      s6_q3_r  <= prod3_c[31:17];
      s6_n5_r  <= s5_d_r[LN_ALT][DIF_W-1];
      s6_n3_r  <= s5_d_r[LN_HDG][DIF_W-1];
      s7_dur_r <= s6_dur_r;
      s7_side_r <= {(s6_n5_r ? -PITCH_W'(q5_c) : PITCH_W'(q5_c)),
                    (s6_n3_r ? -ROLL_W'(q3_c) : ROLL_W'(q3_c)),
                    s6_bat_r};
    end
  end

  logic                        d_vld;
  logic [LANES-1:0][VAL_W-1:0] d_quo;
  logic [DSW-1:0]              d_side;

  wti_div_pipe #(.SW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_num   (s7_num_r),
    .in_dur   (s7_dur_r),
    .in_side  (s7_side_r),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (d_side),
    .busy     (d_busy)
  );

  assign busy = s0_vld_r | s1_vld_r | m_busy | s2_vld_r | s3_vld_r | s4_vld_r | s5_vld_r |
                s6_vld_r | s7_vld_r | d_busy | out_valid;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_latitude  <= d_quo[LN_LAT][30:0];
      out_pos_longitude <= d_quo[LN_LON][31:0];
      out_pos_altitude  <= d_quo[LN_ALT][24:0];
      out_cur_speed     <= d_quo[LN_SPD][16:0];
      out_yaw           <= d_quo[LN_HDG][15:0];
      {out_pitch, out_roll, out_battery} <= d_side;
    end
  end

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_kind == KIND_LOAD)) |-> !busy)
    else $error("load transaction taken while a query is in flight");

  a_seg_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> ({1'b0, s3_seg_r} < s3_n_r))
    else $error("selected segment beyond the waypoints in use");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch >= -12'sd2000) && (out_pitch <= 12'sd2000)))
    else $error("pitch outside its clamp");

  a_battery_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_battery <= BATT_FULL))
    else $error("battery above full charge");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s7_vld_r))
    else $error("pipeline moved while the output was held");
`endif

endmodule

/* tb/wti_checker.sv */
// Transaction monitor, waypoint loop predictor and result comparator for the interpolator.
`timescale 1ns / 1ps
module wti_checker
  import wti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_kind,
  input  logic [2:0]         in_slot,
  input  logic signed [30:0] in_latitude,
  input  logic signed [31:0] in_longitude,
  input  logic signed [24:0] in_altitude,
  input  logic [16:0]        in_speed,
  input  logic [15:0]        in_heading,
  input  logic [19:0]        in_duration,
  input  logic [31:0]        in_elapsed_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [30:0] out_pos_latitude,
  input  logic signed [31:0] out_pos_longitude,
  input  logic signed [24:0] out_pos_altitude,
  input  logic [16:0]        out_cur_speed,
  input  logic [15:0]        out_yaw,
  input  logic signed [11:0] out_pitch,
  input  logic signed [12:0] out_roll,
  input  logic [13:0]        out_battery,
  output int                 fail_count,
  output int                 pending,
  output int                 loads_seen,
  output int                 positions_checked
);

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [24:0] alt;
    logic [16:0]        spd;
    logic [15:0]        yaw;
    logic signed [11:0] pitch;
    logic signed [12:0] roll;
    logic [13:0]        batt;
  } position_t;

  wpt_t        track[8];
  logic [19:0] leg_ms[8];
  logic [3:0]  count_reg;
  position_t   position_q[$];

  function automatic longint blend(longint a, longint b, longint off, longint dur);
    if (dur == 0) return a;
    return (a * dur + off * (b - a)) / dur;
  endfunction

  function automatic longint limit(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  function automatic position_t locate(logic [31:0] elapsed);
    position_t p;
    int        n, seg, nxt;
    longint    loop_ms, t, acc, off, dur, drain;
    n = (count_reg == 0) ? 1 : (count_reg > 8 ? 8 : int'(count_reg));
    loop_ms = 0;
    for (int i = 0; i < n; i++) loop_ms += leg_ms[i];
    t = (loop_ms == 0) ? 0 : longint'(elapsed) % loop_ms;
    acc = 0;
    seg = n - 1;
    off = 0;
    for (int i = 0; i < n; i++) begin
      if (t < acc + leg_ms[i]) begin
        seg = i;
        off = t - acc;
        break;
      end
      acc += leg_ms[i];
    end
    nxt = (seg + 1) % n;
    dur = leg_ms[seg];
    p.lat   = 31'(blend(track[seg].lat, track[nxt].lat, off, dur));
    p.lon   = 32'(blend(track[seg].lon, track[nxt].lon, off, dur));
    p.alt   = 25'(blend(track[seg].alt, track[nxt].alt, off, dur));
    p.spd   = 17'(blend(longint'(track[seg].spd), longint'(track[nxt].spd), off, dur));
    p.yaw   = 16'(blend(longint'(track[seg].hdg), longint'(track[nxt].hdg), off, dur));
    p.pitch = 12'(limit((longint'(track[nxt].alt) - longint'(track[seg].alt)) / 5, 2000));
    p.roll  = 13'(limit((longint'(track[nxt].hdg) - longint'(track[seg].hdg)) / 3, 3000));
    drain = longint'(elapsed) / 10;
    p.batt = 14'((drain >= 10000) ? 0 : 10000 - drain);
    return p;
  endfunction

  always @(posedge clk) begin
    position_t want, got;
    if (!rst_n) begin
      count_reg = 4'd8;
      position_q.delete();
      for (int i = 0; i < 8; i++) begin
        track[i] = '0;
        leg_ms[i] = '0;
      end
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_LOAD) begin
          track[in_slot] = '{in_latitude, in_longitude, in_altitude, in_speed, in_heading};
          leg_ms[in_slot] = in_duration;
          loads_seen++;
        end else begin
          position_q.push_back(locate(in_elapsed_ms));
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_pos_latitude, out_pos_longitude, out_pos_altitude, out_cur_speed,
                out_yaw, out_pitch, out_roll, out_battery};
        if (position_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result with no query outstanding", $realtime);
        end else begin
          want = position_q.pop_front();
          positions_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch lat %0d/%0d lon %0d/%0d alt %0d/%0d spd %0d/%0d ",
                        "yaw %0d/%0d pitch %0d/%0d roll %0d/%0d batt %0d/%0d (exp/act)"},
                       $realtime, want.lat, got.lat, want.lon, got.lon, want.alt, got.alt,
                       want.spd, got.spd, want.yaw, got.yaw, want.pitch, got.pitch,
                       want.roll, got.roll, want.batt, got.batt);
          end
        end
      end
    end
    pending = position_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    loads_seen = 0;
    positions_checked = 0;
  end

endmodule

/* tb/tb_waypoint_track_interpolator.sv */
// Stimulus, back-pressure and verdict for the waypoint track interpolator.
`timescale 1ns / 1ps
module tb_waypoint_track_interpolator;
  import wti_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  logic               clk, rst_n, cfg_we;
  logic [3:0]         cfg_wdata;
  logic               in_valid, in_stall, in_kind;
  logic [2:0]         in_slot;
  logic signed [30:0] in_latitude;
  logic signed [31:0] in_longitude;
  logic signed [24:0] in_altitude;
  logic [16:0]        in_speed;
  logic [15:0]        in_heading;
  logic [19:0]        in_duration;
  logic [31:0]        in_elapsed_ms;
  logic               out_valid, out_stall;
  logic signed [30:0] out_pos_latitude;
  logic signed [31:0] out_pos_longitude;
  logic signed [24:0] out_pos_altitude;
  logic [16:0]        out_cur_speed;
  logic [15:0]        out_yaw;
  logic signed [11:0] out_pitch;
  logic signed [12:0] out_roll;
  logic [13:0]        out_battery;
  int                 fail_count, pending, loads_seen, positions_checked;
  logic               quiet, hold_go;
  int                 hold_cnt, burst_cnt, idle_cycles;

  waypoint_track_interpolator u_top (.*);
  wti_checker u_chk (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Receiver back-pressure: random single stalls, occasional bursts, and one long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
      burst_cnt = 0;
    end else if (hold_go) begin
      hold_cnt = 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (burst_cnt > 0) begin
      burst_cnt--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) burst_cnt = $urandom_range(10, 40);
      out_stall <= (r < 25);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("tb_waypoint_track_interpolator NOT OK");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(logic kind, logic [2:0] slot, logic [30:0] lat, logic [31:0] lon,
                       logic [24:0] alt, logic [16:0] spd, logic [15:0] hdg,
                       logic [19:0] dur, logic [31:0] elapsed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_slot <= slot;
    in_latitude <= lat;
    in_longitude <= lon;
    in_altitude <= alt;
    in_speed <= spd;
    in_heading <= hdg;
    in_duration <= dur;
    in_elapsed_ms <= elapsed;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_slot(logic [2:0] slot, logic [30:0] lat, logic [31:0] lon,
                           logic [24:0] alt, logic [16:0] spd, logic [15:0] hdg,
                           logic [19:0] dur);
    offer(KIND_LOAD, slot, lat, lon, alt, spd, hdg, dur, $urandom());
  endtask

  task automatic query(logic [31:0] elapsed);
    offer(KIND_QUERY, 3'($urandom()), 31'($urandom()), $urandom(), 25'($urandom()),
          17'($urandom()), 16'($urandom()), 20'($urandom()), elapsed);
  endtask

  task automatic random_load();
    logic [30:0] lat;
    logic [24:0] alt;
    logic [15:0] hdg;
    logic [19:0] dur;
    int          r;
    lat = ($urandom_range(0, 3) == 0) ? 31'($urandom())
                                      : 31'(int'($urandom_range(0, 1800000000)) - 900000000);
    alt = ($urandom_range(0, 3) == 0) ? 25'($urandom())
                                      : 25'(int'($urandom_range(0, 10100000)) - 100000);
    hdg = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 35999));
    r = $urandom_range(0, 99);
    if (r < 5) dur = '0;
    else if (r < 50) dur = 20'($urandom_range(1, 200));
    else if (r < 90) dur = 20'($urandom_range(1, 1000000));
    else dur = 20'($urandom());
    load_slot(3'($urandom()), lat, $urandom(), alt, 17'($urandom()), hdg, dur);
  endtask

  task automatic random_query();
    query(($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 120000)) : $urandom());
  endtask

  // Lets every outstanding query drain before the register may change.
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic [3:0] value);
    drain_all();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int items, logic no_idle, logic with_hold);
    quiet = no_idle;
    for (int i = 0; i < items; i++) begin
      if (with_hold && i == items / 3) hold_go <= 1'b1;
      else hold_go <= 1'b0;
      if ($urandom_range(0, 99) < 15) random_load();
      else random_query();
    end
    hold_go <= 1'b0;
    quiet = 1'b0;
  endtask

  initial begin
    logic [3:0] counts[6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_LOAD;
    in_slot = '0;
    in_latitude = '0;
    in_longitude = '0;
    in_altitude = '0;
    in_speed = '0;
    in_heading = '0;
    in_duration = '0;
    in_elapsed_ms = '0;
    quiet = 1'b0;
    hold_go = 1'b0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every slot is loaded before the first query, with the field extremes spread over them.
    load_slot(3'd0, 31'sd900000000, 32'sd1800000000, 25'sd10000000, 17'd100000, 16'd35999,
              20'd1);
    load_slot(3'd1, -31'sd900000000, -32'sd1800000000, -25'sd100000, 17'd0, 16'd0,
              20'd1000000);
    load_slot(3'd2, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 25'h0FF_FFFF, 17'h1FFFF, 16'hFFFF,
              20'hFFFFF);
    load_slot(3'd3, 31'h4000_0000, 32'h8000_0000, 25'h100_0000, 17'd0, 16'd0, 20'd0);
    load_slot(3'd4, 31'sd0, 32'sd0, 25'sd0, 17'd50, 16'd18000, 20'd7);
    load_slot(3'd5, 31'sd1234567, -32'sd7654321, 25'sd3000, 17'd777, 16'd100, 20'd10);
    load_slot(3'd6, -31'sd5, 32'sd5, 25'sd20000, 17'd99999, 16'd30000, 20'd3);
    load_slot(3'd7, 31'sd42, -32'sd42, -25'sd20000, 17'd1, 16'd35999, 20'd500000);
    query(32'd0);
    query(32'hFFFF_FFFF);
    query(32'd99999);
    query(32'd100000);
    query(32'd100009);
    query(32'd1000000);
    query(32'd1000001);
    query(32'd2000005);
    // A single-slot loop whose duration is zero collapses onto that slot.
    set_count(4'd1);
    load_slot(3'd0, 31'sd1000, 32'sd2000, 25'sd3000, 17'd400, 16'd500, 20'd0);
    query(32'd777);
    // In a two-slot loop the zero-duration leg is skipped.
    set_count(4'd2);
    load_slot(3'd1, -31'sd1000, -32'sd2000, 25'sd9000, 17'd40, 16'd9000, 20'd5);
    query(32'd3);
    query(32'd4);

    for (int p = 0; p < 6; p++) begin
      set_count(counts[p]);
      run_phase(135, p == 4, p == 2);
    end

    drain_all();
    $display("Checked %0d position results over %0d waypoint loads,", positions_checked,
             loads_seen);
    $display("with loop sizes from one to eight slots and a long output hold.");
    if (fail_count == 0) begin
      $display("tb_waypoint_track_interpolator OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb_waypoint_track_interpolator NOT OK");
    end
    $finish;
  end

endmodule
